// ----- design/osle_pkg.sv -----
// shared types, constants and helpers for the ordered slot list editor
package osle_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int IDX_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int POS_W     = 5;
	localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_SWAP   = 3'd2;
	localparam logic [2:0] OP_BYPASS = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic ST_OK  = 1'b0;
	localparam logic ST_REJ = 1'b1;

	typedef struct packed {
		logic [2:0] req_type;
		logic [4:0] index;
		logic [4:0] index_b;
		logic [7:0] stage_id;
		logic       bypass_value;
	} osle_req_t;

	typedef struct packed {
		logic       status;
		logic [4:0] chain_count;
		logic [7:0] read_stage;
		logic       read_bypass;
	} osle_rsp_t;

	typedef struct packed {
		logic cmd_load;
		logic edit_en;
		logic rsp_load;
	} osle_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} osle_state_t;

	// position field widened to the compare width
	function automatic logic [CMP_W-1:0] pos_ext(input logic [POS_W-1:0] p);
		return CMP_W'(p);
	endfunction

	// position field as a cell address
	function automatic logic [IDX_W-1:0] slot_addr(input logic [POS_W-1:0] p);
		logic [CMP_W-1:0] w;
		w = CMP_W'(p);
		return w[IDX_W-1:0];
	endfunction

endpackage

// ----- design/osle_ctrl.sv -----
// controller state machine: accept, edit, respond
module osle_ctrl
	import osle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	output osle_ctrl_t ctrl
);

	osle_state_t state_q, state_d;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctrl.rsp_load;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		busy    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.cmd_load = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				ctrl.edit_en = 1'b1;
				state_d      = S_RESP;
			end
			S_RESP: begin
				ctrl.rsp_load = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign done = done_q;

endmodule

// ----- design/osle_dp.sv -----
// datapath: command register, row of slot cells, response register
module osle_dp
	import osle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  osle_ctrl_t ctrl,
	input  osle_req_t  req,
	output osle_rsp_t  rsp
);

	osle_req_t        cmd_q;
	osle_rsp_t        rsp_q;
	logic [7:0]       stage_q [MAX_SLOTS];
	logic             byp_q   [MAX_SLOTS];
	logic [CNT_W-1:0] count_q;
	logic             status_q;

	logic [7:0]       stage_d [MAX_SLOTS];
	logic             byp_d   [MAX_SLOTS];
	logic [7:0]       dn_stage [MAX_SLOTS];
	logic             dn_byp   [MAX_SLOTS];
	logic [7:0]       up_stage [MAX_SLOTS];
	logic             up_byp   [MAX_SLOTS];
	logic [CNT_W-1:0] count_d;
	logic             status_d;

	logic [CMP_W-1:0] n_x, ia_x, ib_x, pos_x, cnt_x;
	logic             a_ok, b_ok, ins_ok, rd_ok;
	logic [7:0]       ent_a_stage, ent_b_stage;
	logic             ent_a_byp, ent_b_byp;

	// neighbor taps for the shift
	for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_tap
		if (g > 0) begin : g_up
			assign up_stage[g] = stage_q[g-1];
			assign up_byp[g]   = byp_q[g-1];
		end else begin : g_up0
			assign up_stage[g] = '0;
			assign up_byp[g]   = 1'b0;
		end
		if (g < MAX_SLOTS - 1) begin : g_dn
			assign dn_stage[g] = stage_q[g+1];
			assign dn_byp[g]   = byp_q[g+1];
		end else begin : g_dn0
			assign dn_stage[g] = '0;
			assign dn_byp[g]   = 1'b0;
		end
	end

	assign n_x    = CMP_W'(count_q);
	assign ia_x   = pos_ext(cmd_q.index);
	assign ib_x   = pos_ext(cmd_q.index_b);
	assign a_ok   = ia_x < n_x;
	assign b_ok   = ib_x < n_x;
	assign ins_ok = (cmd_q.stage_id != 8'd0) && (n_x < CMP_W'(MAX_SLOTS));
	assign pos_x  = (ia_x > n_x) ? n_x : ia_x;

	assign ent_a_stage = stage_q[slot_addr(cmd_q.index)];
	assign ent_a_byp   = byp_q[slot_addr(cmd_q.index)];
	assign ent_b_stage = stage_q[slot_addr(cmd_q.index_b)];
	assign ent_b_byp   = byp_q[slot_addr(cmd_q.index_b)];

	always_comb begin
		logic [CMP_W-1:0] ix;
		logic [CMP_W-1:0] ix1;
		count_d  = count_q;
		status_d = ST_REJ;
		unique case (cmd_q.req_type)
			OP_INSERT: if (ins_ok) begin
				count_d  = count_q + CNT_W'(1);
				status_d = ST_OK;
			end
			OP_REMOVE: if (a_ok) begin
				count_d  = count_q - CNT_W'(1);
				status_d = ST_OK;
			end
			OP_SWAP:   status_d = (a_ok && b_ok) ? ST_OK : ST_REJ;
			OP_BYPASS: status_d = a_ok ? ST_OK : ST_REJ;
			OP_READ:   status_d = a_ok ? ST_OK : ST_REJ;
			default:   status_d = ST_REJ;
		endcase
		for (int i = 0; i < MAX_SLOTS; i++) begin
			ix         = CMP_W'(i);
			ix1        = CMP_W'(i + 1);
			stage_d[i] = stage_q[i];
			byp_d[i]   = byp_q[i];
			unique case (cmd_q.req_type)
				OP_INSERT: if (ins_ok) begin
					if (ix == pos_x) begin
						stage_d[i] = cmd_q.stage_id;
						byp_d[i]   = 1'b0;
					end else if (ix > pos_x && ix <= n_x) begin
						stage_d[i] = up_stage[i];
						byp_d[i]   = up_byp[i];
					end
				end
				OP_REMOVE: if (a_ok) begin
					if (ix >= ia_x && ix1 < n_x) begin
						stage_d[i] = dn_stage[i];
						byp_d[i]   = dn_byp[i];
					end else if (ix1 == n_x) begin
						stage_d[i] = '0;
						byp_d[i]   = 1'b0;
					end
				end
				OP_SWAP: if (a_ok && b_ok) begin
					if (ix == ia_x) begin
						stage_d[i] = ent_b_stage;
						byp_d[i]   = ent_b_byp;
					end else if (ix == ib_x) begin
						stage_d[i] = ent_a_stage;
						byp_d[i]   = ent_a_byp;
					end
				end
				OP_BYPASS: if (a_ok && ix == ia_x) begin
					byp_d[i] = cmd_q.bypass_value;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cmd_load) begin
			cmd_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				stage_q[i] <= '0;
				byp_q[i]   <= 1'b0;
			end
			count_q  <= '0;
			status_q <= ST_REJ;
		end else if (ctrl.edit_en) begin
			stage_q  <= stage_d;
			byp_q    <= byp_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	// read back at the command's index after the edit
	assign cnt_x = CMP_W'(count_q);
	assign rd_ok = ia_x < cnt_x;

	always_ff @(posedge clk) begin
		if (ctrl.rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.chain_count <= cnt_x[4:0];
			rsp_q.read_stage  <= rd_ok ? ent_a_stage : 8'd0;
			rsp_q.read_bypass <= rd_ok ? ent_a_byp : 1'b0;
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- design/ordered_slot_list_editor_top.sv -----
// top level of the ordered slot list editor
// an accepted transaction is edited, then its result register is loaded and done is raised with it
// busy is high for the edit and respond cycles, so a new transaction waits until the last one is through
// the whole chain edit (shift, swap or bypass write) is applied to the cell row as one registered update
// reset: arst_n low clears the chain, the count and the controller; no clearing pass
// the result is held until the next result load and cannot be stalled by the receiver
module ordered_slot_list_editor_top
	import osle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	// command side: accepted when start is high and busy is low
	input  logic      start,
	output logic      busy,
	input  osle_req_t req,
	// result side: one-cycle strobe, valid with done
	output logic      done,
	output osle_rsp_t rsp
);

	// command signals from controller to datapath
	osle_ctrl_t ctrl;

	// sequencer: idle, apply the edit, load the result register
	osle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	// cell row holding the chain plus command and result registers
	osle_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ----- design/osle_checker.sv -----
// port-level checks for the ordered slot list editor, bound to the top level
module osle_checker
	import osle_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input osle_rsp_t rsp
);

	// an accepted transaction makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// every accepted transaction gets its result strobe
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result missing after accept");

	// a result strobe comes once the block is free again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an empty read slot carries no bypass bit
	a_empty_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.read_stage == 8'd0) |-> !rsp.read_bypass)
		else $error("bypass set on empty slot");

endmodule

bind ordered_slot_list_editor_top osle_checker u_osle_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
